[rtl/core/sic_pkg.sv]
// ----------------------------------------------------------------------------
// sic_pkg
// Shared result codes and classification flags for the segment
// intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

    typedef enum logic [1:0]
    {
        KIND_NONE      = 2'd0,
        KIND_UNBOUNDED = 2'd1,
        KIND_BOUNDED   = 2'd2
    } kind_t;

    // Classification decided in the front end, carried alongside the divider
    typedef struct packed
    {
        logic parallel;
        logic bounded;
    } cls_t;

endpackage

[rtl/core/sic_front.sv]
// ----------------------------------------------------------------------------
// sic_front
// Four-stage front end: direction vectors, cross products, denominator and
// numerators, then the scaled dividend terms and the parallel and bounded tests.
// ----------------------------------------------------------------------------
module sic_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          p1x,
    input  logic signed [COORD_BITS-1:0]          p1y,
    input  logic signed [COORD_BITS-1:0]          p2x,
    input  logic signed [COORD_BITS-1:0]          p2y,
    input  logic signed [COORD_BITS-1:0]          q1x,
    input  logic signed [COORD_BITS-1:0]          q1y,
    input  logic signed [COORD_BITS-1:0]          q2x,
    input  logic signed [COORD_BITS-1:0]          q2y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [2*COORD_BITS+2:0]        den,
    output logic signed [3*COORD_BITS+2:0]        start_den_x,
    output logic signed [3*COORD_BITS+2:0]        start_den_y,
    output logic signed [3*COORD_BITS+3:0]        dir_num_x,
    output logic signed [3*COORD_BITS+3:0]        dir_num_y,
    output sic_pkg::cls_t                         cls
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int DENW = PW + 1;
    localparam int SW   = C + DENW;
    localparam int MW   = DW + DENW;

    logic [3:0] v_reg;
    logic [3:0] adv;

    logic signed [DW-1:0]   s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg, s1_cx_reg, s1_cy_reg;
    logic signed [C-1:0]    s1_p1x_reg, s1_p1y_reg;

    logic signed [PW-1:0]   s2_aybx_reg, s2_axby_reg, s2_bycx_reg;
    logic signed [PW-1:0]   s2_bxcy_reg, s2_axcy_reg, s2_aycx_reg;
    logic signed [DW-1:0]   s2_ax_reg, s2_ay_reg;
    logic signed [C-1:0]    s2_p1x_reg, s2_p1y_reg;

    logic signed [DENW-1:0] s3_den_reg, s3_numa_reg, s3_numb_reg;
    logic signed [DW-1:0]   s3_ax_reg, s3_ay_reg;
    logic signed [C-1:0]    s3_p1x_reg, s3_p1y_reg;

    logic signed [DENW-1:0] s4_den_reg;
    logic signed [SW-1:0]   s4_sx_reg, s4_sy_reg;
    logic signed [MW-1:0]   s4_dx_reg, s4_dy_reg;
    sic_pkg::cls_t          s4_cls_reg;

    sic_pkg::cls_t          cls_next;

    // num/den within [0,1] for nonzero den; den == 0 passes only when num == 0
    function automatic logic in_unit(input logic signed [DENW-1:0] num,
                                     input logic signed [DENW-1:0] d);
        logic pos_ok;
        logic neg_ok;
        pos_ok = (num >= 0) && (num <= d);
        neg_ok = (num <= 0) && (num >= d);
        return d[DENW-1] ? neg_ok : pos_ok;
    endfunction

    assign adv[3]   = ~v_reg[3] | out_ready;
    assign adv[2]   = ~v_reg[2] | adv[3];
    assign adv[1]   = ~v_reg[1] | adv[2];
    assign adv[0]   = ~v_reg[0] | adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_comb
    begin
        cls_next.parallel = (s3_den_reg == '0);
        cls_next.bounded  = in_unit(s3_numa_reg, s3_den_reg) &&
                            in_unit(s3_numb_reg, s3_den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_ax_reg  <= DW'(p2x) - DW'(p1x);
            s1_ay_reg  <= DW'(p2y) - DW'(p1y);
            s1_bx_reg  <= DW'(q1x) - DW'(q2x);
            s1_by_reg  <= DW'(q1y) - DW'(q2y);
            s1_cx_reg  <= DW'(p1x) - DW'(q1x);
            s1_cy_reg  <= DW'(p1y) - DW'(q1y);
            s1_p1x_reg <= p1x;
            s1_p1y_reg <= p1y;
        end
        if (adv[1])
        begin
            s2_aybx_reg <= PW'(s1_ay_reg) * PW'(s1_bx_reg);
            s2_axby_reg <= PW'(s1_ax_reg) * PW'(s1_by_reg);
            s2_bycx_reg <= PW'(s1_by_reg) * PW'(s1_cx_reg);
            s2_bxcy_reg <= PW'(s1_bx_reg) * PW'(s1_cy_reg);
            s2_axcy_reg <= PW'(s1_ax_reg) * PW'(s1_cy_reg);
            s2_aycx_reg <= PW'(s1_ay_reg) * PW'(s1_cx_reg);
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_p1x_reg  <= s1_p1x_reg;
            s2_p1y_reg  <= s1_p1y_reg;
        end
        if (adv[2])
        begin
            s3_den_reg  <= DENW'(s2_aybx_reg) - DENW'(s2_axby_reg);
            s3_numa_reg <= DENW'(s2_bycx_reg) - DENW'(s2_bxcy_reg);
            s3_numb_reg <= DENW'(s2_axcy_reg) - DENW'(s2_aycx_reg);
            s3_ax_reg   <= s2_ax_reg;
            s3_ay_reg   <= s2_ay_reg;
            s3_p1x_reg  <= s2_p1x_reg;
            s3_p1y_reg  <= s2_p1y_reg;
        end
        if (adv[3])
        begin
            s4_den_reg <= s3_den_reg;
            s4_sx_reg  <= SW'(s3_p1x_reg) * SW'(s3_den_reg);
            s4_sy_reg  <= SW'(s3_p1y_reg) * SW'(s3_den_reg);
            s4_dx_reg  <= MW'(s3_ax_reg) * MW'(s3_numa_reg);
            s4_dy_reg  <= MW'(s3_ay_reg) * MW'(s3_numa_reg);
            s4_cls_reg <= cls_next;
        end
    end

    assign out_valid   = v_reg[3];
    assign den         = s4_den_reg;
    assign start_den_x = s4_sx_reg;
    assign start_den_y = s4_sy_reg;
    assign dir_num_x   = s4_dx_reg;
    assign dir_num_y   = s4_dy_reg;
    assign cls         = s4_cls_reg;

endmodule

[rtl/core/sic_divider.sv]
// ----------------------------------------------------------------------------
// sic_divider
// Two-lane pipelined restoring divider: dividend sum, magnitudes, overflow
// check, one quotient bit per stage, then rounding, saturation and result.
// ----------------------------------------------------------------------------
module sic_divider #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [2*COORD_BITS+2:0]        den,
    input  logic signed [3*COORD_BITS+2:0]        start_den_x,
    input  logic signed [3*COORD_BITS+2:0]        start_den_y,
    input  logic signed [3*COORD_BITS+3:0]        dir_num_x,
    input  logic signed [3*COORD_BITS+3:0]        dir_num_y,
    input  sic_pkg::cls_t                         cls,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sic_pkg::kind_t                        kind,
    output logic signed [COORD_BITS-1:0]          x,
    output logic signed [COORD_BITS-1:0]          y,
    output logic                                  sat
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * DW;
    localparam int DENW = PW + 1;
    localparam int SW   = C + DENW;
    localparam int MW   = DW + DENW;
    localparam int NUMW = MW + 1;
    localparam int N    = C + 4;

    localparam logic [C:0]          HALF = (C+1)'(1) << (C - 1);
    localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};
    localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    logic signed [SW-1:0]   sd_in [2];
    logic signed [MW-1:0]   dn_in [2];

    logic signed [NUMW-1:0] num_reg  [2];
    logic signed [DENW-1:0] den0_reg;
    logic [NUMW-1:0]        anum_reg [2];
    logic                   nneg_reg [2];
    logic [DENW-1:0]        aden_reg;
    logic                   dneg_reg;

    logic [DENW-1:0]        rem_reg  [2][C+1];
    logic [C-1:0]           q_reg    [2][C+1];
    logic [C-1:0]           lo_reg   [2][C];
    logic                   ovf_reg  [2][C+1];
    logic                   neg_reg  [2][C+1];
    logic [DENW-1:0]        ad_reg   [C+1];
    sic_pkg::cls_t          cls_reg  [N-1];

    logic signed [C-1:0]    lane_val [2];
    logic                   lane_sat [2];

    sic_pkg::kind_t         kind_reg;
    logic signed [C-1:0]    x_reg, y_reg;
    logic                   sat_reg;

    assign sd_in[0] = start_den_x;
    assign sd_in[1] = start_den_y;
    assign dn_in[0] = dir_num_x;
    assign dn_in[1] = dir_num_y;

    assign adv[N-1] = ~v_reg[N-1] | out_ready;
    for (genvar k = 0; k < N - 1; k++)
    begin : g_adv
        assign adv[k] = ~v_reg[k] | adv[k+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
            begin
                if (adv[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Sideband: classification flags ride along every stage
    always_ff @(posedge clk)
    begin
        if (adv[0]) cls_reg[0] <= cls;
        for (int k = 1; k < N - 1; k++)
        begin
            if (adv[k]) cls_reg[k] <= cls_reg[k-1];
        end
    end

    // Shared denominator stages
    always_ff @(posedge clk)
    begin
        if (adv[0]) den0_reg <= den;
        if (adv[1])
        begin
            aden_reg <= den0_reg[DENW-1] ? DENW'(-den0_reg) : DENW'(den0_reg);
            dneg_reg <= den0_reg[DENW-1];
        end
        if (adv[2]) ad_reg[0] <= aden_reg;
        for (int j = 1; j <= C; j++)
        begin
            if (adv[j+2]) ad_reg[j] <= ad_reg[j-1];
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [C:0] mag;
        logic       rnd;
        logic       neg_f;

        always_ff @(posedge clk)
        begin
            if (adv[0])
            begin
                num_reg[l] <= NUMW'(sd_in[l]) + NUMW'(dn_in[l]);
            end
            if (adv[1])
            begin
                anum_reg[l] <= num_reg[l][NUMW-1] ? NUMW'(-num_reg[l]) : NUMW'(num_reg[l]);
                nneg_reg[l] <= num_reg[l][NUMW-1];
            end
            if (adv[2])
            begin
                // quotient of 2**C or more always clips
                ovf_reg[l][0] <= anum_reg[l] >= NUMW'({aden_reg, {C{1'b0}}});
                neg_reg[l][0] <= nneg_reg[l] ^ dneg_reg;
                rem_reg[l][0] <= anum_reg[l][C +: DENW];
                lo_reg[l][0]  <= anum_reg[l][C-1:0];
                q_reg[l][0]   <= '0;
            end
        end

        for (genvar j = 1; j <= C; j++)
        begin : g_iter
            logic [DENW:0] trial;
            logic          ge;

            assign trial = {rem_reg[l][j-1], lo_reg[l][j-1][C-1]};
            assign ge    = trial >= {1'b0, ad_reg[j-1]};

            always_ff @(posedge clk)
            begin
                if (adv[j+2])
                begin
                    rem_reg[l][j] <= ge ? DENW'(trial - {1'b0, ad_reg[j-1]}) : DENW'(trial);
                    q_reg[l][j]   <= {q_reg[l][j-1][C-2:0], ge};
                    ovf_reg[l][j] <= ovf_reg[l][j-1];
                    neg_reg[l][j] <= neg_reg[l][j-1];
                end
            end

            if (j < C)
            begin : g_lo
                always_ff @(posedge clk)
                begin
                    if (adv[j+2]) lo_reg[l][j] <= lo_reg[l][j-1] << 1;
                end
            end
        end

        // round half away from zero on the magnitude, then clip
        assign rnd   = {rem_reg[l][C], 1'b0} >= {1'b0, ad_reg[C]};
        assign mag   = {1'b0, q_reg[l][C]} + (C+1)'(rnd);
        assign neg_f = neg_reg[l][C];

        always_comb
        begin
            lane_sat[l] = ovf_reg[l][C] || (neg_f ? (mag > HALF) : (mag > HALF - 1'b1));
            if (lane_sat[l])
            begin
                lane_val[l] = neg_f ? CMIN : CMAX;
            end
            else
            begin
                lane_val[l] = neg_f ? C'(-mag) : C'(mag);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[N-1])
        begin
            if (cls_reg[N-2].parallel)
            begin
                kind_reg <= sic_pkg::KIND_NONE;
                x_reg    <= '0;
                y_reg    <= '0;
                sat_reg  <= 1'b0;
            end
            else
            begin
                kind_reg <= cls_reg[N-2].bounded ? sic_pkg::KIND_BOUNDED
                                                 : sic_pkg::KIND_UNBOUNDED;
                x_reg    <= lane_val[0];
                y_reg    <= lane_val[1];
                sat_reg  <= lane_sat[0] | lane_sat[1];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign kind      = kind_reg;
    assign x         = x_reg;
    assign y         = y_reg;
    assign sat       = sat_reg;

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == sic_pkg::KIND_NONE |-> x == '0 && y == '0 && !sat)
        else $error("parallel result carries a nonzero point");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat |-> x == CMIN || x == CMAX || y == CMIN || y == CMAX)
        else $error("saturated flag without a clipped coordinate");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> &v_reg)
        else $error("input stalled while a pipeline slot is empty");

endmodule

[rtl/core/segment_intersection_classifier_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_classifier_core
// Crossing point and bounded/unbounded classification of two segments.
// ----------------------------------------------------------------------------
// Pipeline: four front-end stages, three divider setup stages, one restoring
//   stage per quotient bit, one rounding and saturation stage.
// Throughput: one transaction per cycle when not stalled; empty stages close up under stall.
// Reset clears the valid bits only; data registers are not reset.
module segment_intersection_classifier_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // crossing_x, crossing_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
    // crossing_kind[1:0], point_saturated
    output logic [2:0]                               m_axis_tuser
);

    localparam int C    = COORD_BITS;
    localparam int DENW = 2 * (C + 1) + 1;
    localparam int SW   = C + DENW;
    localparam int MW   = C + 1 + DENW;
    localparam int OW   = ((2*COORD_BITS+7)/8)*8;

    logic                   f_valid, f_ready;
    logic signed [DENW-1:0] f_den;
    logic signed [SW-1:0]   f_sx, f_sy;
    logic signed [MW-1:0]   f_dx, f_dy;
    sic_pkg::cls_t          f_cls;

    sic_pkg::kind_t         kind;
    logic signed [C-1:0]    cx, cy;
    logic                   sat;

    sic_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .p1x         (s_axis_tdata[0*C +: C]),
        .p1y         (s_axis_tdata[1*C +: C]),
        .p2x         (s_axis_tdata[2*C +: C]),
        .p2y         (s_axis_tdata[3*C +: C]),
        .q1x         (s_axis_tdata[4*C +: C]),
        .q1y         (s_axis_tdata[5*C +: C]),
        .q2x         (s_axis_tdata[6*C +: C]),
        .q2y         (s_axis_tdata[7*C +: C]),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .den         (f_den),
        .start_den_x (f_sx),
        .start_den_y (f_sy),
        .dir_num_x   (f_dx),
        .dir_num_y   (f_dy),
        .cls         (f_cls)
    );

    sic_divider #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (f_valid),
        .in_ready    (f_ready),
        .den         (f_den),
        .start_den_x (f_sx),
        .start_den_y (f_sy),
        .dir_num_x   (f_dx),
        .dir_num_y   (f_dy),
        .cls         (f_cls),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .kind        (kind),
        .x           (cx),
        .y           (cy),
        .sat         (sat)
    );

    assign m_axis_tdata = OW'({cy, cx});
    assign m_axis_tuser = {sat, kind};

endmodule
